@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/gmf_pkg.sv @@
// ----------------------------------------------------------------------------
// gmf_pkg
// shared types and constants of the grayscale morphology filter
// ----------------------------------------------------------------------------
package gmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 7;
    localparam int HALF_MAX   = MAX_KERNEL / 2;
    localparam int LINE_BUFS  = MAX_KERNEL - 1;
    localparam int LB_IDX_W   = $clog2(LINE_BUFS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = 16;
    localparam int HALF_W     = $clog2(HALF_MAX + 1);
    localparam int KIDX_W     = $clog2(MAX_KERNEL);
    localparam int LAG_MAX    = HALF_MAX * MAX_WIDTH + HALF_MAX;
    localparam int PEND_W     = $clog2(LAG_MAX + 2);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PIX_W      = 8;
    localparam int MASK_W     = 49;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int CFG_IDX_W  = 3;
    localparam int KSIZE_W    = 3;
    localparam int MODE_W     = 2;
    localparam int FWIDTH_W   = 11;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int MODE_ERODE_BIT = 0;
    localparam int MODE_GRAD_BIT  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE  = 3'd0,
        CFG_ELEMENT_MASK = 3'd1,
        CFG_FILTER_MODE  = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
    } gmf_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } gmf_rsp_t;

    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] pix_col_t;

    typedef struct packed {
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] mn;
    } col_red_t;

    typedef struct packed {
        logic                  shift;
        logic [MAX_KERNEL-1:0] mask;
    } cell_ctrl_t;

endpackage

@@ design/grayscale_morphology_filter.sv @@
// ----------------------------------------------------------------------------
// grayscale_morphology_filter: dilation, erosion and gradient over a k x k window
// one item per clock unless req_stall; results pass the stage registers and queue
// rate set by one line ram port pair per buffered row and one column cell step
// reset clears counters, pipeline and queue, restores registers; line rams kept
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grayscale_morphology_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  gmf_pkg::gmf_req_t                req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output gmf_pkg::gmf_rsp_t                rsp_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmf_pkg::MASK_W-1:0]       cfg_data
);
    import gmf_pkg::*;

    // configuration
    logic [KSIZE_W-1:0]  ksize_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [FWIDTH_W-1:0] fwidth_reg;
    logic [ROW_W-1:0]    fheight_reg;

    logic [HALF_W-1:0]   half;
    logic [KIDX_W-1:0]   kside;
    logic [EW_W-1:0]     eff_w;
    logic [ROW_W-1:0]    eff_h;
    logic [PEND_W-1:0]   lag;
    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0] win_mask;

    // frame position counters
    logic [ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [LB_IDX_W-1:0] in_line_reg;
    logic [LB_IDX_W-1:0] out_line_reg;

    logic              accept;
    logic              is_pix;
    logic              emit_now;
    logic              in_col_wrap;
    logic              in_row_wrap;
    logic              out_col_wrap;
    logic              out_row_wrap;
    logic              border_now;
    logic              last_now;
    logic [LB_IDX_W-1:0] q_now;
    logic [COL_W-1:0]  rd_addr;

    // stage 1
    logic                s1_valid_reg;
    logic                s1_pix_reg;
    logic                s1_emit_reg;
    logic [PIX_W-1:0]    s1_data_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    logic                s1_border_reg;
    logic                s1_last_reg;
    logic [LB_IDX_W-1:0] s1_q_reg;
    logic                fwd_reg;
    logic [LINE_BUFS-1:0][PIX_W-1:0] fwd_data_reg;
    logic [LINE_BUFS-1:0][PIX_W-1:0] ram_rd;
    logic [LINE_BUFS-1:0][PIX_W-1:0] rdv;
    pix_col_t            vcol;
    logic                wr_en;

    // stage 2
    logic             s2_emit_reg;
    logic             s2_flush_reg;
    logic             s2_border_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] s2_pass_reg;
    logic [PIX_W-1:0] centre;

    // stage 3
    logic             s3_emit_reg;
    logic             s3_border_reg;
    logic             s3_last_reg;
    logic [PIX_W-1:0] s3_pass_reg;
    logic [PIX_W-1:0] mx_all;
    logic [PIX_W-1:0] mn_all;
    gmf_rsp_t         push_data;

    // column cells
    pix_col_t   cell_in   [MAX_KERNEL];
    pix_col_t   cell_out  [MAX_KERNEL];
    col_red_t   cell_red  [MAX_KERNEL];
    cell_ctrl_t cell_ctrl [MAX_KERNEL];

    logic [FIFO_AW:0]   fifo_count;
    logic [FIFO_AW+1:0] occ;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksize_reg   <= KSIZE_W'(3);
            mask_reg    <= MASK_W'(186);
            mode_reg    <= '0;
            fwidth_reg  <= FWIDTH_W'(640);
            fheight_reg <= ROW_W'(480);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KERNEL_SIZE:  ksize_reg   <= cfg_data[KSIZE_W-1:0];
                CFG_ELEMENT_MASK: mask_reg    <= cfg_data;
                CFG_FILTER_MODE:  mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_FRAME_WIDTH:  fwidth_reg  <= cfg_data[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT: fheight_reg <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(ksize_reg >> 1) > HALF_MAX)
        begin
            half = HALF_W'(HALF_MAX);
        end
        else
        begin
            half = HALF_W'(ksize_reg >> 1);
        end
        kside = KIDX_W'({half, 1'b1});
        if (fwidth_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (int'(fwidth_reg) > MAX_WIDTH)
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(fwidth_reg);
        end
        eff_h = (fheight_reg == '0) ? ROW_W'(1) : fheight_reg;
        lag   = PEND_W'(int'(half) * int'(eff_w) + int'(half));
    end

    // cell c holds the pixels c columns and r rows back from the newest one
    always_comb
    begin
        int idx;
        idx = 0;
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                idx = (2 * int'(half) - r) * int'(kside) + (2 * int'(half) - c);
                if (r <= 2 * int'(half) && c <= 2 * int'(half))
                begin
                    win_mask[c][r] = mask_reg[MASK_IDX_W'(idx)];
                end
                else
                begin
                    win_mask[c][r] = 1'b0;
                end
            end
        end
    end

    assign occ = (FIFO_AW + 2)'(fifo_count) + (FIFO_AW + 2)'(s1_emit_reg)
               + (FIFO_AW + 2)'(s2_emit_reg) + (FIFO_AW + 2)'(s3_emit_reg);
    assign req_stall = (occ >= (FIFO_AW + 2)'(FIFO_DEPTH));
    assign accept    = req_valid & ~req_stall;
    assign is_pix    = (req_data.req_type == REQ_PIXEL);

    always_comb
    begin
        if (is_pix)
        begin
            emit_now = (pend_reg >= lag);
        end
        else
        begin
            emit_now = (pend_reg != '0) && (in_row_reg == '0) && (in_col_reg == '0);
        end
        in_col_wrap  = (EW_W'(in_col_reg) + EW_W'(1)) >= eff_w;
        in_row_wrap  = ((ROW_W + 1)'(in_row_reg) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_h);
        out_col_wrap = (EW_W'(out_col_reg) + EW_W'(1)) >= eff_w;
        out_row_wrap = ((ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_h);
        border_now   = (out_row_reg < ROW_W'(half))
                    || (((ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(half)) >= (ROW_W + 1)'(eff_h))
                    || (out_col_reg < COL_W'(half))
                    || (((EW_W + 1)'(out_col_reg) + (EW_W + 1)'(half)) >= (EW_W + 1)'(eff_w));
        last_now     = (out_row_reg == eff_h - ROW_W'(1))
                    && (EW_W'(out_col_reg) == eff_w - EW_W'(1));
        // line buffer holding the output row, counted back from the newest full row
        q_now        = in_line_reg - LB_IDX_W'(1) - out_line_reg;
        rd_addr      = is_pix ? in_col_reg : out_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            pend_reg     <= '0;
            in_line_reg  <= '0;
            out_line_reg <= '0;
        end
        else if (accept)
        begin
            if (is_pix)
            begin
                if (in_col_wrap)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_wrap ? '0 : in_row_reg + ROW_W'(1);
                    in_line_reg <= in_line_reg + LB_IDX_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
                if (!emit_now)
                begin
                    pend_reg <= pend_reg + PEND_W'(1);
                end
            end
            else if (emit_now)
            begin
                pend_reg <= pend_reg - PEND_W'(1);
            end
            if (emit_now)
            begin
                if (out_col_wrap)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_wrap ? '0 : out_row_reg + ROW_W'(1);
                    out_line_reg <= out_line_reg + LB_IDX_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // stage 1: line ram read data, write back, window shift
    assign wr_en = s1_valid_reg & s1_pix_reg;

    always_comb
    begin
        for (int r = 0; r < LINE_BUFS; r++)
        begin
            rdv[r] = fwd_reg ? fwd_data_reg[r] : ram_rd[r];
        end
        vcol[0] = s1_data_reg;
        for (int r = 1; r < MAX_KERNEL; r++)
        begin
            vcol[r] = rdv[r-1];
        end
    end

    for (genvar r = 0; r < LINE_BUFS; r++)
    begin : g_line
        gmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (s1_addr_reg),
            .wr_data (vcol[r]),
            .rd_en   (accept),
            .rd_addr (rd_addr),
            .rd_data (ram_rd[r])
        );
    end

    for (genvar c = 0; c < MAX_KERNEL; c++)
    begin : g_cell
        assign cell_ctrl[c].shift = wr_en;
        assign cell_ctrl[c].mask  = win_mask[c];
        if (c == 0)
        begin : g_head
            assign cell_in[c] = vcol;
        end
        else
        begin : g_link
            assign cell_in[c] = cell_out[c-1];
        end
        gmf_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl[c]),
            .col_in  (cell_in[c]),
            .col_out (cell_out[c]),
            .red     (cell_red[c])
        );
    end

    assign centre = cell_out[KIDX_W'(half)][KIDX_W'(half)];

    // stage 3: combine the column results
    always_comb
    begin
        mx_all = '0;
        mn_all = PIX_MAX;
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            if (cell_red[c].mx > mx_all)
            begin
                mx_all = cell_red[c].mx;
            end
            if (cell_red[c].mn < mn_all)
            begin
                mn_all = cell_red[c].mn;
            end
        end
        priority if (s3_border_reg)
        begin
            push_data.pixel_out = mode_reg[MODE_GRAD_BIT] ? '0 : s3_pass_reg;
        end
        else if (mode_reg[MODE_GRAD_BIT])
        begin
            push_data.pixel_out = mx_all - mn_all;
        end
        else
        begin
            push_data.pixel_out = mode_reg[MODE_ERODE_BIT] ? mn_all : mx_all;
        end
        push_data.frame_last = s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pix_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_emit_reg  <= 1'b0;
            s2_flush_reg <= 1'b0;
            s3_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_pix_reg   <= accept & is_pix;
            s1_emit_reg  <= accept & emit_now;
            fwd_reg      <= accept & wr_en & (rd_addr == s1_addr_reg);
            s2_emit_reg  <= s1_emit_reg;
            s2_flush_reg <= s1_valid_reg & ~s1_pix_reg;
            s3_emit_reg  <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg   <= req_data.pixel_in;
            s1_addr_reg   <= in_col_reg;
            s1_border_reg <= border_now;
            s1_last_reg   <= last_now;
            s1_q_reg      <= q_now;
        end
        fwd_data_reg  <= vcol[LINE_BUFS-1:0];
        s2_border_reg <= s1_border_reg;
        s2_last_reg   <= s1_last_reg;
        s2_pass_reg   <= (int'(s1_q_reg) < LINE_BUFS) ? rdv[s1_q_reg] : '0;
        s3_border_reg <= s2_border_reg;
        s3_last_reg   <= s2_last_reg;
        s3_pass_reg   <= s2_flush_reg ? s2_pass_reg : centre;
    end

    gmf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_emit_reg),
        .push_data (push_data),
        .pop_valid (rsp_valid),
        .pop_stall (rsp_stall),
        .pop_data  (rsp_data),
        .count     (fifo_count)
    );

    `GMF_ASSERT(a_occ_bound, clk, rst_n, occ <= (FIFO_AW + 2)'(FIFO_DEPTH), "result queue overbooked")
    `GMF_ASSERT(a_push_room, clk, rst_n, !s3_emit_reg || int'(fifo_count) < FIFO_DEPTH, "push into full queue")
    `GMF_ASSERT_NEXT(a_pixel_emit, clk, rst_n, accept && is_pix && pend_reg >= lag, s1_emit_reg, "missed result on pixel transfer")

endmodule

@@ design/gmf_ram.sv @@
// ----------------------------------------------------------------------------
// gmf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/gmf_cell.sv @@
// ----------------------------------------------------------------------------
// gmf_cell
// one window column: holds MAX_KERNEL vertical pixels, hands them to the next column
// and reduces its masked pixels to a registered max and min
// ----------------------------------------------------------------------------
module gmf_cell (
    input  logic                clk,
    input  gmf_pkg::cell_ctrl_t ctrl,
    input  gmf_pkg::pix_col_t   col_in,
    output gmf_pkg::pix_col_t   col_out,
    output gmf_pkg::col_red_t   red
);
    import gmf_pkg::*;

    pix_col_t col_reg;
    col_red_t red_reg;
    col_red_t red_next;

    always_comb
    begin
        red_next.mx = '0;
        red_next.mn = PIX_MAX;
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            if (ctrl.mask[r])
            begin
                if (col_reg[r] > red_next.mx)
                begin
                    red_next.mx = col_reg[r];
                end
                if (col_reg[r] < red_next.mn)
                begin
                    red_next.mn = col_reg[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
        red_reg <= red_next;
    end

    assign col_out = col_reg;
    assign red     = red_reg;

endmodule

@@ design/gmf_out_fifo.sv @@
// ----------------------------------------------------------------------------
// gmf_out_fifo
// small result queue between the filter pipeline and the result channel
// ----------------------------------------------------------------------------
module gmf_out_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  gmf_pkg::gmf_rsp_t        push_data,
    output logic                     pop_valid,
    input  logic                     pop_stall,
    output gmf_pkg::gmf_rsp_t        pop_data,
    output logic [gmf_pkg::FIFO_AW:0] count
);
    import gmf_pkg::*;

    gmf_rsp_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid & ~pop_stall;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (FIFO_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (FIFO_AW + 1)'(1);
            end
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: grayscale morphology filter
// streams whole and partial frames under many register settings, drains each frame with
// flush ticks and compares every output pixel against a software window filter
// kept in step with the accepted transfers; random bursts, gaps and stalls
// ----------------------------------------------------------------------------
module testbench;
    import gmf_pkg::*;

    localparam int HIST_DEPTH = 2 * LAG_MAX + 1;

    class morph_scoreboard;
        int unsigned       ksize;
        logic [MASK_W-1:0] emask;
        int unsigned       fmode;
        int unsigned       fwidth;
        int unsigned       fheight;
        logic [PIX_W-1:0]  history [HIST_DEPTH];
        int                wr_ptr;
        int                pending;
        int                in_row, in_col, out_row, out_col;
        gmf_rsp_t          expected_pixels [$];
        int                errors;

        function new();
            ksize   = 3;
            emask   = MASK_W'(186);
            fmode   = 0;
            fwidth  = 640;
            fheight = 480;
            wr_ptr  = 0;
            pending = 0;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
            errors  = 0;
            foreach (history[i]) history[i] = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [MASK_W-1:0] val);
            case (idx)
                CFG_KERNEL_SIZE:  ksize   = val[KSIZE_W-1:0];
                CFG_ELEMENT_MASK: emask   = val;
                CFG_FILTER_MODE:  fmode   = val[MODE_W-1:0];
                CFG_FRAME_WIDTH:  fwidth  = val[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT: fheight = val[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function int half_k();
            return (ksize / 2 > HALF_MAX) ? HALF_MAX : ksize / 2;
        endfunction

        function int width_eff();
            if (fwidth == 0) return 1;
            if (fwidth > MAX_WIDTH) return MAX_WIDTH;
            return fwidth;
        endfunction

        function int height_eff();
            return (fheight == 0) ? 1 : fheight;
        endfunction

        function logic [PIX_W-1:0] tap(int back);
            int idx;
            idx = (wr_ptr - 1 - back) % HIST_DEPTH;
            if (idx < 0) idx += HIST_DEPTH;
            return history[idx];
        endfunction

        function void step_pos(ref int row, ref int col);
            col++;
            if (col >= width_eff()) begin
                col = 0;
                row++;
                if (row >= height_eff()) row = 0;
            end
        endfunction

        function logic [PIX_W-1:0] window_pixel();
            int h, k, w, ht, self;
            bit grad, border;
            logic [PIX_W-1:0] mx, mn, v;
            h    = half_k();
            k    = 2 * h + 1;
            w    = width_eff();
            ht   = height_eff();
            self = pending - 1;
            grad = fmode[MODE_GRAD_BIT];
            border = out_row < h || out_row + h >= ht || out_col < h || out_col + h >= w;
            mx = '0;
            mn = PIX_MAX;
            if (border) return grad ? '0 : tap(self);
            for (int i = 0; i < k; i++)
                for (int j = 0; j < k; j++)
                    if (emask[i * k + j]) begin
                        v = tap(self - ((i - h) * w + (j - h)));
                        if (v > mx) mx = v;
                        if (v < mn) mn = v;
                    end
            if (grad) return mx - mn;
            return fmode[MODE_ERODE_BIT] ? mn : mx;
        endfunction

        function void emit_pixel();
            gmf_rsp_t r;
            r.pixel_out  = window_pixel();
            r.frame_last = (out_row == height_eff() - 1) && (out_col == width_eff() - 1);
            expected_pixels.push_back(r);
            step_pos(out_row, out_col);
            pending--;
        endfunction

        function void note_input(gmf_req_t r);
            int lag;
            lag = half_k() * width_eff() + half_k();
            if (r.req_type == REQ_PIXEL) begin
                history[wr_ptr] = r.pixel_in;
                wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
                step_pos(in_row, in_col);
                pending++;
                if (pending > lag) emit_pixel();
            end
            else if (pending > 0 && in_row == 0 && in_col == 0) begin
                emit_pixel();
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(gmf_rsp_t got);
            gmf_rsp_t exp_px;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected output pixel %0d", got.pixel_out));
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.pixel_out !== exp_px.pixel_out)
                report($sformatf("pixel_out %0d, expected %0d",
                                 got.pixel_out, exp_px.pixel_out));
            if (got.frame_last !== exp_px.frame_last)
                report($sformatf("frame_last %0b, expected %0b",
                                 got.frame_last, exp_px.frame_last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    gmf_req_t          req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    gmf_rsp_t          rsp_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0] cfg_data;

    morph_scoreboard sb;
    int burst_left;
    int items_sent;
    int hold_cnt;
    bit hold_go;
    int pat_left;
    int stall_pct;

    grayscale_morphology_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // receiver stall pattern, with an occasional long hold
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cnt--;
        end
        else if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_cnt  = 300;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pat_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
    end

    task automatic send_item(gmf_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        sb.note_input(r);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [MASK_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int k, logic [MASK_W-1:0] m, int md, int w, int h);
        write_reg(CFG_KERNEL_SIZE, MASK_W'(k));
        write_reg(CFG_ELEMENT_MASK, m);
        write_reg(CFG_FILTER_MODE, MASK_W'(md));
        write_reg(CFG_FRAME_WIDTH, MASK_W'(w));
        write_reg(CFG_FRAME_HEIGHT, MASK_W'(h));
    endtask

    task automatic send_pixel(bit extremes);
        gmf_req_t r;
        r.req_type = REQ_PIXEL;
        if (extremes || $urandom_range(0, 7) == 0)
            r.pixel_in = $urandom_range(0, 1) ? PIX_MAX : '0;
        else
            r.pixel_in = PIX_W'($urandom_range(0, 255));
        send_item(r);
    endtask

    task automatic send_flush();
        gmf_req_t r;
        r.req_type = REQ_FLUSH;
        r.pixel_in = PIX_W'($urandom_range(0, 255));
        send_item(r);
    endtask

    // partial > 0: send that many pixels with zero lag, then realign to frame start
    task automatic run_phase(int k, logic [MASK_W-1:0] m, int md, int w, int h,
                             int frames, bit extremes, int partial, bit long_hold);
        int n;
        wait_idle();
        set_all(k, m, md, w, h);
        if (long_hold) hold_go = 1'b1;
        n = (partial > 0) ? partial : frames * sb.width_eff() * sb.height_eff();
        for (int i = 0; i < n; i++)
        begin
            if (partial == 0 && $urandom_range(0, 9) == 0) send_flush();
            send_pixel(extremes);
        end
        while (sb.pending > 0) send_flush();
        if (partial > 0)
        begin
            wait_idle();
            set_all(1, m, md, 1, 1);
            send_pixel(1'b0);
        end
    endtask

    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return MASK_W'({$urandom, $urandom});
        endcase
    endfunction

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        rsp_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        burst_left  = 0;
        items_sent  = 0;
        hold_cnt    = 0;
        hold_go     = 1'b0;
        pat_left    = 0;
        stall_pct   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme pixels under dilation and erosion, saturating width,
        // largest height, odd settings, a long receiver hold that fills the queue
        run_phase(3, '1, 0, 3, 3, 1, 1'b1, 0, 1'b0);
        run_phase(3, '1, 1, 3, 3, 1, 1'b1, 0, 1'b0);
        run_phase(0, '0, 3, 2047, 1, 1, 1'b1, 20, 1'b0);
        run_phase(1, '1, 2, 0, 65535, 1, 1'b1, 12, 1'b0);
        run_phase(7, '1, 2, 7, 7, 1, 1'b0, 0, 1'b1);

        phase = 0;
        while (items_sent < 520)
        begin
            run_phase($urandom_range(0, 7), rand_mask(), $urandom_range(0, 3),
                      $urandom_range(0, 14), $urandom_range(0, 10),
                      $urandom_range(1, 2), 1'b0, 0, phase == 2);
            phase++;
        end
        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ grayscale_morphology_filter.f @@
+incdir+design
design/gmf_pkg.sv
design/gmf_ram.sv
design/gmf_cell.sv
design/gmf_out_fifo.sv
design/grayscale_morphology_filter.sv
sim/testbench.sv
